>>> sv/bdlp_pkg.sv
// Shared types and constants of the button debouncer with long press and auto-repeat.
`timescale 1ns / 1ps

package bdlp_pkg;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_PRESSED       = 3'd1,
        EV_CLICK         = 3'd2,
        EV_RELEASED_LONG = 3'd3,
        EV_LONG          = 3'd4,
        EV_REPEAT        = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_REPEAT     = 2'd2,
        REG_ACTIVE     = 2'd3
    } reg_index_t;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [15:0] REPEAT_RESET     = 16'd200;
    localparam logic        ACTIVE_RESET     = 1'b0;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_ms;
        logic        active_level;
    } cfg_t;

    typedef struct packed {
        logic        last_raw;
        logic [31:0] edge_time;
        logic        stable_pressed;
        logic [31:0] press_start;
        logic [31:0] repeat_time;
        logic        long_active;
    } btn_state_t;

    localparam btn_state_t BTN_STATE_RESET = '{
        last_raw:       ~ACTIVE_RESET,
        edge_time:      32'd0,
        stable_pressed: 1'b0,
        press_start:    32'd0,
        repeat_time:    32'd0,
        long_active:    1'b1
    };

    typedef struct packed {
        event_t event_code;
        logic   is_pressed;
        logic   state_changed;
    } eval_result_t;

endpackage

>>> sv/bdlp_poll_if.sv
// Poll channel carrying one raw button sample per item.
`timescale 1ns / 1ps

interface bdlp_poll_if;
    logic        valid;
    logic        ready;
    logic [2:0]  button_index;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output button_index, output pin_level, output now_ms,
                    input ready);
    modport sink (input valid, input button_index, input pin_level, input now_ms,
                  output ready);
endinterface

>>> sv/bdlp_result_if.sv
// Result channel carrying one button event per item.
`timescale 1ns / 1ps

interface bdlp_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] button_id;
    logic [2:0] event_code;
    logic       is_pressed;
    logic       state_changed;

    modport source (output valid, output button_id, output event_code, output is_pressed,
                    output state_changed, input ready);
    modport sink (input valid, input button_id, input event_code, input is_pressed,
                  input state_changed, output ready);
endinterface

>>> sv/bdlp_cfg_if.sv
// Configuration write channel with register index and write data.
`timescale 1ns / 1ps

interface bdlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/bdlp_cfg_regs.sv
// Configuration registers shared by all buttons.
`timescale 1ns / 1ps

module bdlp_cfg_regs
    import bdlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bdlp_cfg_if.sink       cfg,
    output cfg_t           settings
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign settings  = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.repeat_ms     <= REPEAT_RESET;
            cfg_reg.active_level  <= ACTIVE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_DEBOUNCE:   cfg_reg.debounce_ms   <= cfg.data;
                REG_LONG_PRESS: cfg_reg.long_press_ms <= cfg.data;
                REG_REPEAT:     cfg_reg.repeat_ms     <= cfg.data;
                REG_ACTIVE:     cfg_reg.active_level  <= cfg.data[0];
                default:        cfg_reg.active_level  <= cfg_reg.active_level;
            endcase
        end
    end

endmodule

>>> sv/bdlp_state_store.sv
// Per-button state registers with one read and one write address.
`timescale 1ns / 1ps

module bdlp_state_store
    import bdlp_pkg::*;
#(
    parameter int BUTTONS = 8,
    parameter int IDX_W   = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_index,
    output btn_state_t       rd_state,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  btn_state_t       wr_state
);

    btn_state_t state_reg [BUTTONS];

    assign rd_state = state_reg[rd_index];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BUTTONS; b++)
            begin
                state_reg[b] <= BTN_STATE_RESET;
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_index] <= wr_state;
        end
    end

endmodule

>>> sv/bdlp_eval.sv
// Debounce and event decision for one poll of one button.
`timescale 1ns / 1ps

module bdlp_eval
    import bdlp_pkg::*;
(
    input  cfg_t         settings,
    input  btn_state_t   cur,
    input  logic         pin_level,
    input  logic [31:0]  now_ms,
    output btn_state_t   nxt,
    output eval_result_t res
);

    logic [31:0] edge_next;
    logic [31:0] since_edge;
    logic [31:0] since_press;
    logic [31:0] since_repeat;
    logic        lvl;
    logic        changed;
    logic        pressed_now;
    btn_state_t  mid;

    always_comb
    begin
        edge_next  = (pin_level != cur.last_raw) ? now_ms : cur.edge_time;
        since_edge = now_ms - edge_next;
        lvl        = (pin_level == settings.active_level);
        changed    = (since_edge >= 32'(settings.debounce_ms)) && (lvl != cur.stable_pressed);
        pressed_now = changed && lvl;

        mid                = cur;
        mid.last_raw       = pin_level;
        mid.edge_time      = edge_next;
        mid.stable_pressed = changed ? lvl : cur.stable_pressed;
        if (pressed_now)
        begin
            mid.press_start = now_ms;
            mid.long_active = 1'b0;
            mid.repeat_time = 32'd0;
        end

        since_press  = now_ms - cur.press_start;
        since_repeat = now_ms - cur.repeat_time;

        nxt               = mid;
        res.event_code    = EV_NONE;
        res.is_pressed    = mid.stable_pressed;
        res.state_changed = changed;

        if (changed)
        begin
            if (mid.stable_pressed)
            begin
                res.event_code = EV_PRESSED;
            end
            else
            begin
                res.event_code = mid.long_active ? EV_RELEASED_LONG : EV_CLICK;
            end
        end
        else if (mid.stable_pressed)
        begin
            if (!mid.long_active)
            begin
                if (since_press >= 32'(settings.long_press_ms))
                begin
                    nxt.long_active = 1'b1;
                    nxt.repeat_time = now_ms;
                    res.event_code  = EV_LONG;
                end
            end
            else if (since_repeat >= 32'(settings.repeat_ms))
            begin
                nxt.repeat_time = now_ms;
                res.event_code  = EV_REPEAT;
            end
        end
    end

endmodule

>>> sv/button_debounce_long_press.sv
// Top level of the polling button debouncer with long press and auto-repeat.
//
//   Channel  Dir  Handshake      Payload
//   poll     in   valid/ready    button_index, pin_level, now_ms
//   result   out  valid/ready    button_id, event_code, is_pressed, state_changed
//   cfg      in   valid/ready    index, data (always ready)
//
// Each item passes from acceptance into the poll register, and from there through the
// state read-modify-write into the result register.
// A new item is accepted every cycle unless the result stalls; the per-button state is written as the item
// leaves the poll register, so back-to-back polls of one button see fresh state.
// Reset restores every button's state and the settings to their defaults at once.
// A stalled result holds, and the poll register still accepts one item behind it.
`timescale 1ns / 1ps

module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int BUTTONS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    bdlp_poll_if.sink       poll,
    bdlp_result_if.source   result,
    bdlp_cfg_if.sink        cfg
);

    localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    cfg_t         settings;
    btn_state_t   cur_state;
    btn_state_t   new_state;
    eval_result_t eval_res;

    logic        s1_valid_reg;
    logic [2:0]  s1_index_reg;
    logic        s1_pin_reg;
    logic [31:0] s1_now_reg;

    logic        out_valid_reg;
    logic [2:0]  out_id_reg;
    logic [2:0]  out_event_reg;
    logic        out_pressed_reg;
    logic        out_changed_reg;

    logic             advance;
    logic             index_ok;
    logic [IDX_W-1:0] slot;

    assign advance     = !out_valid_reg || result.ready;
    assign poll.ready  = !s1_valid_reg || advance;
    assign index_ok    = (32'(s1_index_reg) < BUTTONS);
    assign slot        = IDX_W'(s1_index_reg);

    assign result.valid         = out_valid_reg;
    assign result.button_id     = out_id_reg;
    assign result.event_code    = out_event_reg;
    assign result.is_pressed    = out_pressed_reg;
    assign result.state_changed = out_changed_reg;

    bdlp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    bdlp_state_store #(
        .BUTTONS (BUTTONS),
        .IDX_W   (IDX_W)
    ) u_state_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_index (slot),
        .rd_state (cur_state),
        .wr_en    (advance && s1_valid_reg && index_ok),
        .wr_index (slot),
        .wr_state (new_state)
    );

    bdlp_eval u_eval (
        .settings  (settings),
        .cur       (cur_state),
        .pin_level (s1_pin_reg),
        .now_ms    (s1_now_reg),
        .nxt       (new_state),
        .res       (eval_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            s1_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.ready && poll.valid)
        begin
            s1_index_reg <= poll.button_index;
            s1_pin_reg   <= poll.pin_level;
            s1_now_reg   <= poll.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_id_reg <= s1_index_reg;
            if (index_ok)
            begin
                out_event_reg   <= eval_res.event_code;
                out_pressed_reg <= eval_res.is_pressed;
                out_changed_reg <= eval_res.state_changed;
            end
            else
            begin
                out_event_reg   <= EV_NONE;
                out_pressed_reg <= 1'b0;
                out_changed_reg <= 1'b0;
            end
        end
    end

endmodule
